[design/adaptive_onset_detector_macros.svh]
// Assertion macros used by the checker file.
`ifndef ADAPTIVE_ONSET_DETECTOR_MACROS_SVH
`define ADAPTIVE_ONSET_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AOD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define AOD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/aod_pkg.sv]
// ----------------------------------------------------------------------------
// aod_pkg
// Shared types and constants of the adaptive onset detector.
// ----------------------------------------------------------------------------
package aod_pkg;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [15:0] RANK_RESET  = 16'd64225;
  localparam logic [15:0] DECAY_RESET = 16'd65470;
  localparam logic [15:0] ACT_KEEP    = 16'd64881;
  localparam logic [15:0] ACT_GAIN    = 16'd655;   // 65536 - ACT_KEEP
  localparam logic [6:0]  CTRL_MAX    = 7'd127;
  localparam logic [3:0]  DIV_LAST    = 4'd15;      // 16 fraction bits

  typedef enum logic [2:0] {
    REG_UP    = 3'd0,
    REG_DOWN  = 3'd1,
    REG_RLO   = 3'd2,
    REG_RHI   = 3'd3,
    REG_TWO   = 3'd4,
    REG_SEED  = 3'd5,
    REG_RANK  = 3'd6,
    REG_DECAY = 3'd7
  } aod_reg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SMUL1,
    OP_SMUL2,
    OP_COMMIT,
    OP_PASS,
    OP_TMUL1,
    OP_TMUL2,
    OP_TSUM,
    OP_DIV_INIT_L,
    OP_DIV_INIT_C,
    OP_DIV_STEP,
    OP_DIV_END_L,
    OP_DIV_END_C,
    OP_AMUL,
    OP_ASUM,
    OP_OUT
  } aod_op_t;

  typedef struct packed {
    aod_op_t op;
    logic    rd_en;
  } aod_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pass_last;
  } aod_status_t;

endpackage

[design/aod_ram.sv]
// ----------------------------------------------------------------------------
// aod_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module aod_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/aod_ctrl.sv]
// ----------------------------------------------------------------------------
// aod_ctrl
// Sequencer: smoothing, commit, radix-select scan passes, threshold update,
// two divisions, activity update and output hand-off.
// ----------------------------------------------------------------------------
module aod_ctrl #(
  parameter int WINDOW = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  input  aod_pkg::aod_status_t      status,
  output aod_pkg::aod_cmd_t         cmd,
  output logic [$clog2(WINDOW)-1:0] rd_addr
);
  import aod_pkg::*;

  localparam int AW = $clog2(WINDOW);

  typedef enum logic [4:0] {
    S_IDLE, S_SMUL1, S_SMUL2, S_COMMIT, S_SCAN, S_DRAIN, S_PASS,
    S_TMUL1, S_TMUL2, S_TSUM, S_DIVL_INIT, S_DIVL, S_DIVL_END,
    S_DIVC_INIT, S_DIVC, S_DIVC_END, S_AMUL, S_ASUM, S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [3:0]      step_r, step_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign rd_addr   = addr_r;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_NONE;
    cmd.rd_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_SMUL1;
        end
      end
      S_SMUL1: begin
        cmd.op    = OP_SMUL1;
        state_nxt = S_SMUL2;
      end
      S_SMUL2: begin
        cmd.op    = OP_SMUL2;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.op    = OP_COMMIT;
        addr_nxt  = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        addr_nxt  = addr_r + AW'(1);
        if (status.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_PASS;
      end
      S_PASS: begin
        cmd.op    = OP_PASS;
        addr_nxt  = '0;
        state_nxt = status.pass_last ? S_TMUL1 : S_SCAN;
      end
      S_TMUL1: begin
        cmd.op    = OP_TMUL1;
        state_nxt = S_TMUL2;
      end
      S_TMUL2: begin
        cmd.op    = OP_TMUL2;
        state_nxt = S_TSUM;
      end
      S_TSUM: begin
        cmd.op    = OP_TSUM;
        state_nxt = S_DIVL_INIT;
      end
      S_DIVL_INIT: begin
        cmd.op    = OP_DIV_INIT_L;
        step_nxt  = '0;
        state_nxt = S_DIVL;
      end
      S_DIVL: begin
        cmd.op   = OP_DIV_STEP;
        step_nxt = step_r + 4'd1;
        if (step_r == DIV_LAST) begin
          state_nxt = S_DIVL_END;
        end
      end
      S_DIVL_END: begin
        cmd.op    = OP_DIV_END_L;
        state_nxt = S_DIVC_INIT;
      end
      S_DIVC_INIT: begin
        cmd.op    = OP_DIV_INIT_C;
        step_nxt  = '0;
        state_nxt = S_DIVC;
      end
      S_DIVC: begin
        cmd.op   = OP_DIV_STEP;
        step_nxt = step_r + 4'd1;
        if (step_r == DIV_LAST) begin
          state_nxt = S_DIVC_END;
        end
      end
      S_DIVC_END: begin
        cmd.op    = OP_DIV_END_C;
        state_nxt = S_AMUL;
      end
      S_AMUL: begin
        cmd.op    = OP_AMUL;
        state_nxt = S_ASUM;
      end
      S_ASUM: begin
        cmd.op    = OP_ASUM;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      addr_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/aod_dp.sv]
// ----------------------------------------------------------------------------
// aod_dp
// Datapath: config registers, window RAMs, smoothing, radix select,
// threshold filter, shared restoring divider and output register.
// ----------------------------------------------------------------------------
module aod_dp #(
  parameter int WINDOW      = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  aod_pkg::aod_cmd_t             cmd,
  input  logic [$clog2(WINDOW)-1:0]     rd_addr,
  output aod_pkg::aod_status_t          status,
  input  logic                          cfg_we,
  input  logic [aod_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [aod_pkg::CFG_DW-1:0]    cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          o_trigger,
  output logic [15:0]                   o_level,
  output logic [15:0]                   o_change,
  output logic [15:0]                   o_activity,
  output logic [6:0]                    o_control,
  output logic [15:0]                   o_threshold
);
  import aod_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int XW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int TW = XW + 8;
  localparam int AW = $clog2(WINDOW);
  localparam int NW = $clog2(WINDOW + 1);
  localparam int BW = $clog2(XW);

  // configuration
  logic [15:0]        up_r, down_r, rank_r, decay_r;
  logic signed [15:0] rlo_r, rhi_r;
  logic               two_r;

  // per-item state
  logic signed [SB-1:0] x_in_r;
  logic [SB+16:0]       sp1_r, sp2_r;
  logic signed [XW-1:0] xc_r, prev_r;
  logic [XW-1:0]        lc_r;
  logic [NW-1:0]        scnt_r, ccnt_r;
  logic [AW-1:0]        head_r;
  logic [TW-1:0]        acc_r;
  logic                 trig_r;
  logic signed [XW-1:0] smin_r, smax_r;
  logic [XW-1:0]        cmin_r, cmax_r;
  logic [XW-1:0]        prefix_r, mask_r;
  logic [NW-1:0]        k_r, cnt_r;
  logic [BW-1:0]        bit_r;
  logic                 rv_r;
  logic [AW-1:0]        ra_r;
  logic [XW+16:0]       tp1_r;
  logic [TW+15:0]       tp2_r;
  logic [XW:0]          rem_r, den_r;
  logic [15:0]          q_r;
  logic                 q0_r;
  logic [15:0]          level_r, change_r, act_r;
  logic [31:0]          ap1_r, ap2_r;

  // ---------------- window memories ----------------
  logic [XW-1:0] sdat, cdat;
  logic          commit;

  assign commit = (cmd.op == OP_COMMIT);

  // ---------------- smoothing and commit ----------------
  logic [SB-1:0]        us, up_u, prev_lo, r_val;
  logic signed [XW-1:0] x_ext, x_sm, xc, rlo_x, rhi_x;
  logic                 rising, have_prev, ranged;
  logic [15:0]          w;
  logic [16:0]          wc;
  logic [SB+17:0]       r_sum;
  logic signed [XW:0]   diff, cmp;
  logic [XW-1:0]        mag;
  logic                 trig_now;
  logic [NW-1:0]        n_new, idx, k_new;
  logic [NW+15:0]       rank_prod;

  assign have_prev = (scnt_r != '0);
  assign ranged    = (rlo_r != '0) || (rhi_r != '0);
  assign rlo_x     = XW'(rlo_r);
  assign rhi_x     = XW'(rhi_r);
  assign x_ext     = XW'(x_in_r);
  assign prev_lo   = prev_r[SB-1:0];
  assign us        = {~x_in_r[SB-1], x_in_r[SB-2:0]};
  assign up_u      = {~prev_lo[SB-1], prev_lo[SB-2:0]};
  assign rising    = x_ext > prev_r;
  assign w         = rising ? up_r : down_r;
  assign wc        = 17'h10000 - {1'b0, w};
  assign r_sum     = (SB+18)'(sp1_r) + (SB+18)'(sp2_r) + (SB+18)'(32768);
  assign r_val     = r_sum[16 +: SB];
  assign x_sm      = have_prev ? XW'($signed({~r_val[SB-1], r_val[SB-2:0]})) : x_ext;

  always_comb begin
    xc = x_sm;
    if (ranged) begin
      if (x_sm < rlo_x) begin
        xc = rlo_x;
      end else if (x_sm > rhi_x) begin
        xc = rhi_x;
      end
    end
  end

  assign diff = (XW+1)'(xc) - (XW+1)'(prev_r);
  assign mag  = diff[XW] ? XW'(-diff) : diff[XW-1:0];
  assign cmp  = two_r ? $signed({1'b0, mag}) : diff;
  assign trig_now = have_prev && (ccnt_r != '0) && ({lc_r, 8'd0} < acc_r)
                    && ($signed({cmp, 8'd0}) > $signed({1'b0, acc_r}));

  assign n_new     = (have_prev && (ccnt_r < NW'(WINDOW))) ? ccnt_r + NW'(1) : ccnt_r;
  assign rank_prod = (NW+16)'(n_new) * (NW+16)'(rank_r);
  assign idx       = rank_prod[16 +: NW];
  assign k_new     = (idx >= n_new) ? n_new - NW'(1) : idx;

  aod_ram #(.WIDTH(XW), .DEPTH(WINDOW)) u_sram (
    .clk(clk), .we(commit), .waddr(head_r), .wdata(xc),
    .raddr(rd_addr), .rdata(sdat)
  );

  aod_ram #(.WIDTH(XW), .DEPTH(WINDOW)) u_cram (
    .clk(clk), .we(commit && have_prev), .waddr(head_r), .wdata(mag),
    .raddr(rd_addr), .rdata(cdat)
  );

  // ---------------- scan accumulation ----------------
  logic s_ok, c_ok, c_match;

  // slot 0 holds the very first sample, which has no difference, until the
  // difference window has filled all the way around
  assign s_ok    = rv_r && (NW'(ra_r) < scnt_r);
  assign c_ok    = s_ok && ((ra_r != '0) || (ccnt_r == scnt_r));
  assign c_match = (((cdat ^ prefix_r) & mask_r) == '0) && !cdat[bit_r];

  assign status.scan_last = (NW'(rd_addr) == scnt_r - NW'(1));
  assign status.pass_last = (bit_r == '0);

  // ---------------- threshold ----------------
  logic [XW-1:0]  cur;
  logic [TW+17:0] t_sum;

  assign cur   = (ccnt_r == '0) ? '0 : prefix_r;
  assign t_sum = (TW+18)'({tp1_r, 8'd0}) + (TW+18)'(tp2_r) + (TW+18)'(32768);

  // ---------------- division operands ----------------
  logic signed [XW-1:0] lo_l, hi_l;
  logic signed [XW:0]   span_l;
  logic                 lvl_ok, x_le, chg_ok, q0_now;
  logic [XW:0]          num_l, num_c, den_c, d_num, d_den, d_t2, d_rem;
  logic [XW+1:0]        d_t, d_sub;
  logic                 d_ge;
  logic [15:0]          div_q;

  assign lo_l   = ranged ? rlo_x : smin_r;
  assign hi_l   = ranged ? rhi_x : smax_r;
  assign span_l = (XW+1)'(hi_l) - (XW+1)'(lo_l);
  assign lvl_ok = span_l > 0;
  assign x_le   = xc_r <= lo_l;
  assign num_l  = (XW+1)'(xc_r) - (XW+1)'(lo_l);
  assign chg_ok = (ccnt_r != '0) && (cmax_r > cmin_r);
  assign num_c  = (XW+1)'(lc_r) - (XW+1)'(cmin_r);
  assign den_c  = (XW+1)'(cmax_r) - (XW+1)'(cmin_r);
  assign d_num  = (cmd.op == OP_DIV_INIT_L) ? num_l : num_c;
  assign d_den  = (cmd.op == OP_DIV_INIT_L) ? span_l : den_c;
  assign q0_now = d_num >= d_den;
  assign d_rem  = q0_now ? d_num - d_den : d_num;
  assign d_t    = {rem_r, 1'b0};
  assign d_ge   = d_t >= {1'b0, den_r};
  assign d_sub  = d_t - {1'b0, den_r};
  assign d_t2   = d_ge ? d_sub[XW:0] : d_t[XW:0];
  assign div_q  = q0_r ? 16'hFFFF : q_r;

  logic [33:0] a_sum;
  logic [22:0] ctl_prod;

  assign a_sum    = 34'(ap1_r) + 34'(ap2_r) + 34'd32768;
  assign ctl_prod = 23'(level_r) * 23'(CTRL_MAX);

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r     <= '0;
      down_r   <= '0;
      rlo_r    <= '0;
      rhi_r    <= '0;
      two_r    <= 1'b0;
      rank_r   <= RANK_RESET;
      decay_r  <= DECAY_RESET;
      acc_r    <= '0;
      scnt_r   <= '0;
      ccnt_r   <= '0;
      head_r   <= '0;
      trig_r   <= 1'b0;
      level_r  <= '0;
      change_r <= '0;
      act_r    <= '0;
      rv_r     <= 1'b0;
    end else begin
      rv_r <= cmd.rd_en;
      if (cfg_we) begin
        case (aod_reg_t'(cfg_index))
          REG_UP:    up_r    <= cfg_data;
          REG_DOWN:  down_r  <= cfg_data;
          REG_RLO:   rlo_r   <= cfg_data;
          REG_RHI:   rhi_r   <= cfg_data;
          REG_TWO:   two_r   <= cfg_data[0];
          REG_SEED: begin
            acc_r  <= TW'({cfg_data, 8'd0});
          end
          REG_RANK:  rank_r  <= cfg_data;
          REG_DECAY: decay_r <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_COMMIT: begin
          trig_r <= trig_now;
          if (have_prev) begin
            ccnt_r <= n_new;
          end
          if (scnt_r < NW'(WINDOW)) begin
            scnt_r <= scnt_r + NW'(1);
          end
          head_r <= (head_r == AW'(WINDOW - 1)) ? '0 : head_r + AW'(1);
        end
        OP_TSUM: begin
          acc_r <= (acc_r == '0) ? TW'({cur, 8'd0}) : t_sum[16 +: TW];
        end
        OP_DIV_END_L: begin
          if (lvl_ok) begin
            level_r <= x_le ? 16'd0 : div_q;
          end
        end
        OP_DIV_END_C: begin
          if (chg_ok) begin
            change_r <= div_q;
          end
        end
        OP_ASUM: begin
          act_r <= a_sum[31:16];
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ra_r <= rd_addr;
    if (s_ok) begin
      if ($signed(sdat) < smin_r) smin_r <= sdat;
      if ($signed(sdat) > smax_r) smax_r <= sdat;
    end
    if (c_ok) begin
      if (cdat < cmin_r) cmin_r <= cdat;
      if (cdat > cmax_r) cmax_r <= cdat;
      if (c_match) cnt_r <= cnt_r + NW'(1);
    end
    case (cmd.op)
      OP_LOAD:  x_in_r <= in_sample;
      OP_SMUL1: sp1_r  <= (SB+17)'(us) * (SB+17)'(wc);
      OP_SMUL2: sp2_r  <= (SB+17)'(up_u) * (SB+17)'(w);
      OP_COMMIT: begin
        xc_r     <= xc;
        prev_r   <= xc;
        smin_r   <= xc;
        smax_r   <= xc;
        cmin_r   <= mag;
        cmax_r   <= mag;
        prefix_r <= '0;
        mask_r   <= '0;
        bit_r    <= BW'(XW - 1);
        cnt_r    <= '0;
        k_r      <= k_new;
        if (have_prev) begin
          lc_r <= mag;
        end
      end
      OP_PASS: begin
        if (k_r >= cnt_r) begin
          prefix_r[bit_r] <= 1'b1;
          k_r             <= k_r - cnt_r;
        end
        mask_r[bit_r] <= 1'b1;
        cnt_r         <= '0;
        if (bit_r != '0) begin
          bit_r <= bit_r - BW'(1);
        end
      end
      OP_TMUL1: tp1_r <= (XW+17)'(cur) * (XW+17)'(17'h10000 - {1'b0, decay_r});
      OP_TMUL2: tp2_r <= (TW+16)'(acc_r) * (TW+16)'(decay_r);
      OP_DIV_INIT_L, OP_DIV_INIT_C: begin
        rem_r <= d_rem;
        den_r <= d_den;
        q0_r  <= q0_now;
        q_r   <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= d_t2;
        q_r   <= {q_r[14:0], d_ge};
      end
      OP_AMUL: begin
        ap1_r <= 32'(change_r) * 32'(ACT_GAIN);
        ap2_r <= 32'(act_r) * 32'(ACT_KEEP);
      end
      OP_OUT: begin
        o_trigger   <= trig_r;
        o_level     <= level_r;
        o_change    <= change_r;
        o_activity  <= act_r;
        o_control   <= (level_r == 16'hFFFF) ? CTRL_MAX : ctl_prod[22:16];
        o_threshold <= acc_r[8 +: 16];
      end
      default: ;
    endcase
  end

endmodule

[design/adaptive_onset_detector.sv]
// ----------------------------------------------------------------------------
// adaptive_onset_detector
// Onset detector with adaptive percentile threshold and window normalization.
// ----------------------------------------------------------------------------
// One sample in, one result out. The time an item takes is set mainly by the
// radix-select percentile search, which makes one pass per difference bit (at
// least 16) over the filled window entries (up to WINDOW) of the window RAM
// through its single read port; sample and difference min/max ride along on
// those passes. The next item is taken only after the current one has
// finished; a finished result waits in the output register without holding
// up input.
module adaptive_onset_detector #(
  parameter int WINDOW      = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_trigger,
  output logic [15:0]                   out_level_norm,
  output logic [15:0]                   out_change_norm,
  output logic [15:0]                   out_activity_level,
  output logic [6:0]                    out_control_value,
  output logic [15:0]                   out_current_threshold,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aod_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [aod_pkg::CFG_DW-1:0]    cfg_data
);
  import aod_pkg::*;

  aod_cmd_t                  cmd;
  aod_status_t               status;
  logic [$clog2(WINDOW)-1:0] rd_addr;

  assign cfg_ready = 1'b1;

  aod_ctrl #(.WINDOW(WINDOW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  aod_dp #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .status      (status),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_sample   (in_sample_in),
    .o_trigger   (out_trigger),
    .o_level     (out_level_norm),
    .o_change    (out_change_norm),
    .o_activity  (out_activity_level),
    .o_control   (out_control_value),
    .o_threshold (out_current_threshold)
  );

endmodule

[design/aod_checker.sv]
// ----------------------------------------------------------------------------
// aod_checker
// Port-level checks of the onset detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "adaptive_onset_detector_macros.svh"

module aod_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic [SAMPLE_BITS-1:0] in_sample_in,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   out_trigger,
  input logic [15:0]            out_level_norm,
  input logic [15:0]            out_change_norm,
  input logic [15:0]            out_activity_level,
  input logic [6:0]             out_control_value,
  input logic [15:0]            out_current_threshold,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [2:0]             cfg_index,
  input logic [15:0]            cfg_data
);

  logic [22:0] ctl_ref;
  assign ctl_ref = 23'(out_level_norm) * 23'd127;

  // one item in flight: input closes right after an accept
  `AOD_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)

  // control value follows level
  `AOD_ASSERT_NOW(a_ctrl_level, out_valid,
    (out_level_norm == 16'hFFFF && out_control_value == 7'd127) ||
    (out_level_norm != 16'hFFFF && out_control_value == ctl_ref[22:16]))

  // a new result needs a new item: no output while input is idle and unused
  `AOD_ASSERT_NEXT(a_no_phantom, !out_valid && !in_stall && !in_valid, !out_valid)

  // a held result stays put
  `AOD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_level_norm) && $stable(out_current_threshold))

endmodule

bind adaptive_onset_detector aod_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_aod_checker (.*);
